@@ hdl/dpid_pkg.sv @@
// ----------------------------------------------------------------------------
// dpid_pkg: shared widths, constants and types for the drive distance PID
// Field widths, register indexes and the control word of the serial MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpid_pkg;

    // field and datapath widths
    localparam int POS_W      = 24;   // encoder position, 1/16 degree
    localparam int TGT_W      = 24;   // target distance, 1/256 inch
    localparam int MAXV_W     = 10;   // velocity limit, rpm
    localparam int GAIN_W     = 16;   // Q0.16 gains and the distance scale
    localparam int VEL_W      = 11;   // velocity output
    localparam int PERR_W     = 32;   // position error output
    localparam int STALL_W    = 16;   // stall timer, ms
    localparam int DIST_W     = 25;   // travelled distance
    localparam int ERR_W      = 26;   // internal error and distance delta
    localparam int INTEG_W    = 40;   // clamped integral
    localparam int MCAND_W    = 40;   // widest multiplicand (integral)
    localparam int ACC_W      = 58;   // sum of the three gain products
    localparam int FRAC_W     = 16;   // Q16 scaling of every product
    localparam int DIV_W      = 27;   // biased position sum
    localparam int REM_W      = 2;    // divider remainder (divisor at most 3)
    localparam int BIAS_SHIFT = 25;   // sum bias is divisor << BIAS_SHIFT

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd4;

    localparam logic [MAXV_W-1:0] MAXV_RESET   = 10'd200;
    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd6400;

    // encoders
    localparam int ENCODER_COUNT_DEF = 3;
    localparam int ENCODER_FIELDS    = 3;

    // control constants
    localparam logic [GAIN_W-1:0]  DIST_SCALE_Q16 = 16'd36602;  // 16*pi/90 in Q16
    localparam logic [STALL_W-1:0] TICK_MS        = 16'd15;
    localparam logic [STALL_W-1:0] STALL_LIMIT_MS = 16'd450;
    localparam int                 SETTLE_BAND    = 128;        // half inch

    // accumulator preset for a multiply pass
    typedef enum logic [1:0] {
        ACC_ZERO,
        ACC_ROUND,
        ACC_KEEP
    } acc_init_t;

    typedef struct packed {
        logic      start;
        acc_init_t init;
    } mul_ctl_t;

endpackage

@@ hdl/dpid_div.sv @@
// ----------------------------------------------------------------------------
// dpid_div: bit-serial divider by a small constant
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpid_div #(
    parameter int DIVISOR = dpid_pkg::ENCODER_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [dpid_pkg::DIV_W-1:0] dividend,
    output logic                      busy,
    output logic [dpid_pkg::DIV_W-1:0] quotient
);

    localparam int DIV_W = dpid_pkg::DIV_W;
    localparam int REM_W = dpid_pkg::REM_W;
    localparam int RSH_W = REM_W + 1;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(DIV_W - 1);
    localparam logic [RSH_W-1:0] DIV_K = RSH_W'(DIVISOR);

    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [RSH_W-1:0] rem_sh;
    logic             fit;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    // shift the next dividend bit into the remainder, subtract when it fits
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[DIV_W-1]};
        fit      = (rem_sh >= DIV_K);
        rem_next = fit ? REM_W'(rem_sh - DIV_K) : rem_sh[REM_W-1:0];
        dq_next  = {dq_reg[DIV_W-2:0], fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

@@ hdl/dpid_mul.sv @@
// ----------------------------------------------------------------------------
// dpid_mul: bit-serial shift-add multiply-accumulate
// Signed multiplicand times unsigned 16-bit multiplier, one multiplier bit
// per cycle, added onto a preset or the running accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpid_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dpid_pkg::mul_ctl_t                 ctl,
    input  logic signed [dpid_pkg::MCAND_W-1:0] mcand,
    input  logic [dpid_pkg::GAIN_W-1:0]         mplier,
    output logic                               busy,
    output logic signed [dpid_pkg::ACC_W-1:0]   acc
);

    localparam int ACC_W   = dpid_pkg::ACC_W;
    localparam int MCAND_W = dpid_pkg::MCAND_W;
    localparam int GAIN_W  = dpid_pkg::GAIN_W;
    localparam int CNT_W   = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        {{(ACC_W - dpid_pkg::FRAC_W){1'b0}}, 1'b1, {(dpid_pkg::FRAC_W - 1){1'b0}}};

    logic signed [ACC_W-1:0] acc_reg, acc_preset, addend;
    logic signed [ACC_W-1:0] mcand_reg;
    logic [GAIN_W-1:0]       mplier_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;

    always_comb
    begin
        unique case (ctl.init)
            dpid_pkg::ACC_ZERO:  acc_preset = '0;
            dpid_pkg::ACC_ROUND: acc_preset = ROUND_BIAS;
            dpid_pkg::ACC_KEEP:  acc_preset = acc_reg;
            default:             acc_preset = acc_reg;
        endcase
        addend = mplier_reg[0] ? mcand_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // advance: add the weighted multiplicand, move to the next multiplier bit
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg    <= acc_preset;
            mcand_reg  <= {{(ACC_W - MCAND_W){mcand[MCAND_W-1]}}, mcand};
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + addend;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

@@ hdl/drive_distance_pid.sv @@
// ----------------------------------------------------------------------------
// drive_distance_pid: closed-loop distance controller for one drive side
// Sequencing: each input transaction runs the bit-serial divider, then the
//   distance pass and the P, I and D passes through the single shared
//   shift-add MAC, one after the other; a new transaction is taken only
//   once the previous result has been handed to the output register.
// Reset: asynchronous, active low; registers take their documented defaults,
//   no move is active and the output holds no transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_distance_pid #(
    parameter int ENCODER_COUNT = dpid_pkg::ENCODER_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [dpid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpid_pkg::CFG_DATA_W-1:0]       cfg_data,

    // input channel: one transaction per control tick
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 restart,
    input  logic signed [dpid_pkg::POS_W-1:0]     pos_a,
    input  logic signed [dpid_pkg::POS_W-1:0]     pos_b,
    input  logic signed [dpid_pkg::POS_W-1:0]     pos_c,

    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [dpid_pkg::VEL_W-1:0]     velocity,
    output logic signed [dpid_pkg::PERR_W-1:0]    position_error,
    output logic [dpid_pkg::STALL_W-1:0]          stall_ms,
    output logic                                 settled,
    output logic                                 stalled
);

    // ------------------------------------------------------------------------
    // Local widths and derived constants
    // ------------------------------------------------------------------------
    localparam int POS_W   = dpid_pkg::POS_W;
    localparam int TGT_W   = dpid_pkg::TGT_W;
    localparam int MAXV_W  = dpid_pkg::MAXV_W;
    localparam int GAIN_W  = dpid_pkg::GAIN_W;
    localparam int VEL_W   = dpid_pkg::VEL_W;
    localparam int PERR_W  = dpid_pkg::PERR_W;
    localparam int STALL_W = dpid_pkg::STALL_W;
    localparam int DIST_W  = dpid_pkg::DIST_W;
    localparam int ERR_W   = dpid_pkg::ERR_W;
    localparam int INTEG_W = dpid_pkg::INTEG_W;
    localparam int MCAND_W = dpid_pkg::MCAND_W;
    localparam int ACC_W   = dpid_pkg::ACC_W;
    localparam int FRAC_W  = dpid_pkg::FRAC_W;
    localparam int DIV_W   = dpid_pkg::DIV_W;
    localparam int CMP_W   = ERR_W + 4;          // holds 10 * error
    localparam int VFULL_W = ACC_W - FRAC_W;     // velocity before clamping

    // Only three position fields exist: clamp the encoder count to 1..3.
    localparam int USED = (ENCODER_COUNT < 1) ? 1 :
                          ((ENCODER_COUNT > dpid_pkg::ENCODER_FIELDS) ?
                           dpid_pkg::ENCODER_FIELDS : ENCODER_COUNT);

    // The sum is biased by USED << BIAS_SHIFT so the divider only ever sees a
    // non-negative dividend; the bias lands above bit POS_W-1 of the quotient,
    // so the low POS_W quotient bits are exactly the floor average.
    localparam logic [DIV_W-1:0] DIV_BIAS = DIV_W'(USED * (2 ** dpid_pkg::BIAS_SHIFT));

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W - 1){1'b0}}};
    localparam logic signed [ERR_W-1:0]   SETTLE_HI = ERR_W'(dpid_pkg::SETTLE_BAND);
    localparam logic signed [ERR_W-1:0]   SETTLE_LO = ERR_W'(-dpid_pkg::SETTLE_BAND);

    // ------------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------------
    typedef enum logic [2:0] {
        S_IDLE,     // wait for an input transaction
        S_DIV,      // serial average of the encoder positions
        S_MOVE,     // move start, stall timer, start the distance multiply
        S_DIST,     // distance = travel * scale, rounded
        S_ERR,      // error, delta, integral accumulate with saturation
        S_CLAMP,    // integral clearing rule, start the P pass
        S_GAIN,     // P, I and D passes through the shared MAC
        S_OUT       // clamp velocity and hand the result to the output
    } state_t;

    typedef enum logic [1:0] {
        PH_P,
        PH_I,
        PH_D
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    // configuration registers
    logic signed [TGT_W-1:0] target_reg;
    logic [MAXV_W-1:0]       max_vel_reg;
    logic [GAIN_W-1:0]       gain_p_reg;
    logic [GAIN_W-1:0]       gain_i_reg;
    logic [GAIN_W-1:0]       gain_d_reg;

    // controller state carried between ticks
    logic                      active_reg;
    logic                      restart_reg;
    logic signed [POS_W-1:0]   start_pos_reg;
    logic signed [POS_W-1:0]   prev_pos_reg;
    logic signed [DIST_W-1:0]  prev_dist_reg;
    logic signed [INTEG_W-1:0] integral_reg;
    logic [STALL_W-1:0]        stall_reg;

    // per-tick working registers
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   delta_reg;

    // output registers
    logic                      out_valid_reg;
    logic signed [VEL_W-1:0]   velocity_reg;
    logic signed [PERR_W-1:0]  perr_reg;
    logic [STALL_W-1:0]        stall_ms_reg;
    logic                      settled_reg;
    logic                      stalled_reg;

    // divider and MAC
    logic                      in_take;
    logic [DIV_W-1:0]          ext_a, ext_b, ext_c, dividend;
    logic                      div_busy;
    logic [DIV_W-1:0]          div_q;
    dpid_pkg::mul_ctl_t        mul_ctl;
    logic signed [MCAND_W-1:0] mul_mcand;
    logic [GAIN_W-1:0]         mul_mplier;
    logic                      mul_busy;
    logic signed [ACC_W-1:0]   mul_acc;

    // datapath nets
    logic signed [POS_W-1:0]   avg;
    logic                      new_move;
    logic signed [POS_W-1:0]   start_next;
    logic signed [DIST_W-1:0]  travel;
    logic [STALL_W:0]          stall_inc;
    logic [STALL_W-1:0]        stall_next;
    logic signed [DIST_W-1:0]  dist_now;
    logic signed [ERR_W-1:0]   dist_ext, target_ext, err_next, delta_next;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [INTEG_W-1:0] target_wide;
    logic signed [CMP_W-1:0]   err_c, tgt_c, err10, tgt3;
    logic                      integ_clear;
    logic signed [VFULL_W-1:0] vel_full, vel_hi, vel_lo, vel_clamp;
    logic signed [VEL_W-1:0]   vel_lim;
    logic                      out_free;

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            max_vel_reg <= dpid_pkg::MAXV_RESET;
            gain_p_reg  <= dpid_pkg::GAIN_P_RESET;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dpid_pkg::CFG_TARGET: target_reg  <= cfg_data[TGT_W-1:0];
                dpid_pkg::CFG_MAXV:   max_vel_reg <= cfg_data[MAXV_W-1:0];
                dpid_pkg::CFG_GAIN_P: gain_p_reg  <= cfg_data[GAIN_W-1:0];
                dpid_pkg::CFG_GAIN_I: gain_i_reg  <= cfg_data[GAIN_W-1:0];
                dpid_pkg::CFG_GAIN_D: gain_d_reg  <= cfg_data[GAIN_W-1:0];
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Position sum and serial average
    // ------------------------------------------------------------------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    assign ext_a = {{(DIV_W - POS_W){pos_a[POS_W-1]}}, pos_a};
    assign ext_b = (USED >= 2) ? {{(DIV_W - POS_W){pos_b[POS_W-1]}}, pos_b} : '0;
    assign ext_c = (USED >= 3) ? {{(DIV_W - POS_W){pos_c[POS_W-1]}}, pos_c} : '0;
    assign dividend = ext_a + ext_b + ext_c + DIV_BIAS;

    dpid_div #(
        .DIVISOR (USED)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_take),
        .dividend (dividend),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign avg = div_q[POS_W-1:0];

    // ------------------------------------------------------------------------
    // Move start and stall timer
    // ------------------------------------------------------------------------
    always_comb
    begin
        new_move   = restart_reg || !active_reg;
        start_next = new_move ? avg : start_pos_reg;
        travel     = {avg[POS_W-1], avg} - {start_next[POS_W-1], start_next};

        // count 15 ms per tick without motion, saturating at full scale
        stall_inc = {1'b0, stall_reg} + {1'b0, dpid_pkg::TICK_MS};
        if (new_move)
        begin
            stall_next = '0;
        end
        else if (avg == prev_pos_reg)
        begin
            stall_next = stall_inc[STALL_W] ? '1 : stall_inc[STALL_W-1:0];
        end
        else
        begin
            stall_next = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Error, delta and integral
    // ------------------------------------------------------------------------
    always_comb
    begin
        // floor((travel * scale + half) / 2^16): take the upper bits
        dist_now   = mul_acc[FRAC_W + DIST_W - 1:FRAC_W];
        dist_ext   = {{(ERR_W - DIST_W){dist_now[DIST_W-1]}}, dist_now};
        target_ext = {{(ERR_W - TGT_W){target_reg[TGT_W-1]}}, target_reg};
        err_next   = target_ext - dist_ext;
        delta_next = dist_ext - {{(ERR_W - DIST_W){prev_dist_reg[DIST_W-1]}}, prev_dist_reg};

        integ_sum = {integral_reg[INTEG_W-1], integral_reg}
                  + {{(INTEG_W + 1 - ERR_W){err_next[ERR_W-1]}}, err_next};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end

        // clear the integral above the target or when 10*error < 3*target
        target_wide = {{(INTEG_W - TGT_W){target_reg[TGT_W-1]}}, target_reg};
        err_c       = {{(CMP_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
        tgt_c       = {{(CMP_W - TGT_W){target_reg[TGT_W-1]}}, target_reg};
        err10       = (err_c <<< 3) + (err_c <<< 1);
        tgt3        = (tgt_c <<< 1) + tgt_c;
        integ_clear = (integral_reg > target_wide) || (err10 < tgt3);
    end

    // ------------------------------------------------------------------------
    // Shared MAC: distance pass, then P, I and D passes into one accumulator
    // ------------------------------------------------------------------------
    always_comb
    begin
        mul_ctl.start = 1'b0;
        mul_ctl.init  = dpid_pkg::ACC_KEEP;
        mul_mcand     = '0;
        mul_mplier    = '0;
        unique case (state_reg)
            S_MOVE:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.init  = dpid_pkg::ACC_ROUND;
                mul_mcand     = {{(MCAND_W - DIST_W){travel[DIST_W-1]}}, travel};
                mul_mplier    = dpid_pkg::DIST_SCALE_Q16;
            end
            S_CLAMP:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.init  = dpid_pkg::ACC_ZERO;
                mul_mcand     = {{(MCAND_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_mplier    = gain_p_reg;
            end
            S_GAIN:
            begin
                mul_ctl.start = !mul_busy && (phase_reg != PH_D);
                mul_ctl.init  = dpid_pkg::ACC_KEEP;
                if (phase_reg == PH_P)
                begin
                    mul_mcand  = integral_reg;
                    mul_mplier = gain_i_reg;
                end
                else
                begin
                    mul_mcand  = {{(MCAND_W - ERR_W){delta_reg[ERR_W-1]}}, delta_reg};
                    mul_mplier = gain_d_reg;
                end
            end
            default: ;
        endcase
    end

    dpid_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .busy   (mul_busy),
        .acc    (mul_acc)
    );

    // ------------------------------------------------------------------------
    // Velocity limit
    // ------------------------------------------------------------------------
    always_comb
    begin
        vel_full = mul_acc[ACC_W-1:FRAC_W];
        vel_hi   = {{(VFULL_W - MAXV_W){1'b0}}, max_vel_reg};
        vel_lo   = -vel_hi;
        if (vel_full > vel_hi)
        begin
            vel_clamp = vel_hi;
        end
        else if (vel_full < vel_lo)
        begin
            vel_clamp = vel_lo;
        end
        else
        begin
            vel_clamp = vel_full;
        end
        vel_lim  = {{(VEL_W - MAXV_W){1'b0}}, max_vel_reg};
        out_free = !out_valid_reg || !out_stall;
    end

    // ------------------------------------------------------------------------
    // Sequencer, controller state and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_P;
            active_reg    <= 1'b0;
            restart_reg   <= 1'b0;
            start_pos_reg <= '0;
            prev_pos_reg  <= '0;
            prev_dist_reg <= '0;
            integral_reg  <= '0;
            stall_reg     <= '0;
            err_reg       <= '0;
            delta_reg     <= '0;
            out_valid_reg <= 1'b0;
            velocity_reg  <= '0;
            perr_reg      <= '0;
            stall_ms_reg  <= '0;
            settled_reg   <= 1'b0;
            stalled_reg   <= 1'b0;
        end
        else
        begin
            // drop the output transaction once it is taken; the output step
            // reloads the register itself
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        restart_reg <= restart;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_MOVE;
                    end
                end
                S_MOVE:
                begin
                    // a new move captures the start and clears the history
                    active_reg    <= 1'b1;
                    start_pos_reg <= start_next;
                    prev_pos_reg  <= avg;
                    stall_reg     <= stall_next;
                    if (new_move)
                    begin
                        integral_reg  <= '0;
                        prev_dist_reg <= '0;
                    end
                    state_reg <= S_DIST;
                end
                S_DIST:
                begin
                    if (!mul_busy)
                    begin
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg       <= err_next;
                    delta_reg     <= delta_next;
                    prev_dist_reg <= dist_now;
                    integral_reg  <= integ_next;
                    state_reg     <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (integ_clear)
                    begin
                        integral_reg <= '0;
                    end
                    phase_reg <= PH_P;
                    state_reg <= S_GAIN;
                end
                S_GAIN:
                begin
                    if (!mul_busy)
                    begin
                        unique case (phase_reg)
                            PH_P:    phase_reg <= PH_I;
                            PH_I:    phase_reg <= PH_D;
                            PH_D:    state_reg <= S_OUT;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        velocity_reg  <= vel_clamp[VEL_W-1:0];
                        perr_reg      <= {{(PERR_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
                        stall_ms_reg  <= stall_reg;
                        settled_reg   <= (err_reg < SETTLE_HI) && (err_reg > SETTLE_LO);
                        stalled_reg   <= (stall_reg >= dpid_pkg::STALL_LIMIT_MS);
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign velocity       = velocity_reg;
    assign position_error = perr_reg;
    assign stall_ms       = stall_ms_reg;
    assign settled        = settled_reg;
    assign stalled        = stalled_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output transaction raised outside the output step");

    a_vel_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (velocity_reg <= vel_lim) && (velocity_reg >= -vel_lim))
        else $error("velocity outside the configured limit");

    a_mul_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_ctl.start |-> !mul_busy)
        else $error("multiply pass started while the MAC is busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !div_busy && !mul_busy)
        else $error("input open while arithmetic units are still running");

endmodule

@@ tb/drive_distance_pid_test.sv @@
// ----------------------------------------------------------------------------
// drive_distance_pid_test: self-checking bench for the drive distance PID
// Feeds control ticks through the valid/stall input channel, rewrites the
// gain, limit and target registers between idle phases, and checks every
// drive command against a cycle-free software copy of the control law.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_distance_pid_test;

    // ------------------------------------------------------------------
    // Widths taken from the package
    // ------------------------------------------------------------------
    localparam int POS_W      = dpid_pkg::POS_W;
    localparam int VEL_W      = dpid_pkg::VEL_W;
    localparam int PERR_W     = dpid_pkg::PERR_W;
    localparam int STALL_W    = dpid_pkg::STALL_W;
    localparam int MAXV_W     = dpid_pkg::MAXV_W;
    localparam int GAIN_W     = dpid_pkg::GAIN_W;
    localparam int CFG_IDX_W  = dpid_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = dpid_pkg::CFG_DATA_W;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int    SAT_TICKS    = 40;    // held position past the stall limit
    localparam int    N_PHASES     = 12;
    localparam int    PHASE_ITEMS  = 86;
    localparam int    HOLD_CYCLES  = 1500;  // long receiver hold-off
    localparam int    TAIL_CYCLES  = 120;   // idle tail after the final drain
    localparam int    ALL_ITEMS    = 30 + SAT_TICKS + N_PHASES * PHASE_ITEMS;
    localparam longint LIMIT_CYCLES =
        3 * (longint'(ALL_ITEMS) * 520 + HOLD_CYCLES + N_PHASES * 200 + 1000);

    // ------------------------------------------------------------------
    // Control law constants
    // ------------------------------------------------------------------
    localparam int     ENC_USED  = (dpid_pkg::ENCODER_COUNT_DEF < 1) ? 1 :
                                   (dpid_pkg::ENCODER_COUNT_DEF > 3) ? 3 :
                                   dpid_pkg::ENCODER_COUNT_DEF;
    localparam longint DIST_Q16  = 36602;   // 16*pi/90 in Q16
    localparam longint HALF_Q16  = 32768;
    localparam longint TICK_STEP = 15;
    localparam longint STALL_TOP = 65535;
    localparam longint STALL_LIM = 450;
    localparam longint SETTLE    = 128;
    localparam longint INTEG_MAX = (longint'(1) <<< 39) - 1;
    localparam longint INTEG_MIN = -(longint'(1) <<< 39);
    localparam int     POS_MAX   = 8388607;
    localparam int     POS_MIN   = -8388608;

    typedef struct packed {
        logic signed [VEL_W-1:0]  velocity;
        logic signed [PERR_W-1:0] position_error;
        logic [STALL_W-1:0]       stall_ms;
        logic                     settled;
        logic                     stalled;
    } tick_result_t;

    typedef struct {
        bit                 rs;
        logic [POS_W-1:0]   a;
        logic [POS_W-1:0]   b;
        logic [POS_W-1:0]   c;
        bit                 lit;
        tick_result_t       res;
    } tick_row_t;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      restart;
    logic signed [POS_W-1:0]   pos_a;
    logic signed [POS_W-1:0]   pos_b;
    logic signed [POS_W-1:0]   pos_c;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [VEL_W-1:0]   velocity;
    logic signed [PERR_W-1:0]  position_error;
    logic [STALL_W-1:0]        stall_ms;
    logic                      settled;
    logic                      stalled;

    drive_distance_pid u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .restart        (restart),
        .pos_a          (pos_a),
        .pos_b          (pos_b),
        .pos_c          (pos_c),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .velocity       (velocity),
        .position_error (position_error),
        .stall_ms       (stall_ms),
        .settled        (settled),
        .stalled        (stalled)
    );

    // ------------------------------------------------------------------
    // Controller shadow: registers and move state, reset values
    // ------------------------------------------------------------------
    longint cfg_target = 0;
    longint cfg_vmax   = 200;
    longint cfg_kp     = 6400;
    longint cfg_ki     = 0;
    longint cfg_kd     = 0;

    bit     move_active = 1'b0;
    longint move_origin = 0;
    longint last_avg    = 0;
    longint last_dist   = 0;
    longint integ_acc   = 0;
    longint stall_acc   = 0;

    tick_result_t drive_cmds[$];    // commands owed by the block, oldest first
    tick_row_t    directed_rows[$];

    int     fail_count  = 0;
    longint cycle_count = 0;
    bit     tx_quiet    = 1'b0;     // sender: no gaps
    bit     rx_quiet    = 1'b0;     // receiver: never stall
    bit     rx_hold_req = 1'b0;     // receiver: one long hold-off

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // One control tick of the PID: update the move state and return
    // the drive command that the block owes for this transaction.
    // ------------------------------------------------------------------
    function automatic tick_result_t pid_tick(input bit rs, input logic [POS_W-1:0] a,
                                              input logic [POS_W-1:0] b,
                                              input logic [POS_W-1:0] c);
        longint       enc [3];
        longint       sum;
        longint       avg;
        longint       travel;
        longint       dist_now;
        longint       err;
        longint       delta;
        longint       acc;
        longint       vel;
        tick_result_t r;
        enc[0] = longint'(signed'(a));
        enc[1] = longint'(signed'(b));
        enc[2] = longint'(signed'(c));
        sum = 0;
        for (int i = 0; i < ENC_USED; i++)
            sum += enc[i];
        // floor average: truncation is wrong for negative remainders
        avg = sum / ENC_USED;
        if ((sum % ENC_USED) != 0 && sum < 0)
            avg -= 1;

        if (rs || !move_active)
        begin
            move_origin = avg;
            move_active = 1'b1;
            integ_acc   = 0;
            last_dist   = 0;
            stall_acc   = 0;
        end
        else if (avg == last_avg)
        begin
            stall_acc += TICK_STEP;
            if (stall_acc > STALL_TOP)
                stall_acc = STALL_TOP;
        end
        else
            stall_acc = 0;

        travel   = avg - move_origin;
        dist_now = (travel * DIST_Q16 + HALF_Q16) >>> 16;
        err      = cfg_target - dist_now;

        integ_acc += err;
        if (integ_acc > INTEG_MAX)
            integ_acc = INTEG_MAX;
        if (integ_acc < INTEG_MIN)
            integ_acc = INTEG_MIN;
        // anti-windup: drop the integral past the target or near the end
        if (integ_acc > cfg_target)
            integ_acc = 0;
        if (err * 10 < cfg_target * 3)
            integ_acc = 0;

        delta = dist_now - last_dist;
        acc   = cfg_kp * err + cfg_ki * integ_acc + cfg_kd * delta;
        vel   = acc >>> 16;
        if (vel > cfg_vmax)
            vel = cfg_vmax;
        if (vel < -cfg_vmax)
            vel = -cfg_vmax;

        last_dist = dist_now;
        last_avg  = avg;

        r.velocity       = vel[VEL_W-1:0];
        r.position_error = err[PERR_W-1:0];
        r.stall_ms       = stall_acc[STALL_W-1:0];
        r.settled        = (err < SETTLE && err > -SETTLE);
        r.stalled        = (stall_acc >= STALL_LIM);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 40);
        return $urandom_range(41, 250);
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_MAX)
            v = POS_MAX;
        if (v < POS_MIN)
            v = POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic void add_row(input bit rs, input int a, input int b, input int c,
                                    input bit lit = 1'b0, input int v = 0,
                                    input int e = 0, input int s = 0,
                                    input bit st = 1'b0, input bit sl = 1'b0);
        tick_row_t row;
        row.rs                 = rs;
        row.a                  = a[POS_W-1:0];
        row.b                  = b[POS_W-1:0];
        row.c                  = c[POS_W-1:0];
        row.lit                = lit;
        row.res.velocity       = v[VEL_W-1:0];
        row.res.position_error = e;
        row.res.stall_ms       = s[STALL_W-1:0];
        row.res.settled        = st;
        row.res.stalled        = sl;
        directed_rows.push_back(row);
    endfunction

    // Offer one tick, hold it until accepted, then log the command it owes.
    task automatic send_tick(input bit rs, input logic [POS_W-1:0] a,
                             input logic [POS_W-1:0] b, input logic [POS_W-1:0] c,
                             input bit use_lit, input tick_result_t lit_res);
        tick_result_t res;
        int           gap;
        restart  <= rs;
        pos_a    <= a;
        pos_b    <= b;
        pos_c    <= c;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        res = pid_tick(rs, a, b, c);
        drive_cmds.push_back(use_lit ? lit_res : res);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drive one register write; the caller drops the enable after a burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            dpid_pkg::CFG_TARGET: cfg_target = longint'(signed'(data));
            dpid_pkg::CFG_MAXV:   cfg_vmax   = longint'(data[MAXV_W-1:0]);
            dpid_pkg::CFG_GAIN_P: cfg_kp     = longint'(data[GAIN_W-1:0]);
            dpid_pkg::CFG_GAIN_I: cfg_ki     = longint'(data[GAIN_W-1:0]);
            dpid_pkg::CFG_GAIN_D: cfg_kd     = longint'(data[GAIN_W-1:0]);
            default: ;
        endcase
    endtask

    // Stop offering and wait until every owed command has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (drive_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain(input int lo_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return CFG_DATA_W'($urandom_range(0, lo_max));
        if (r < 80)
            return CFG_DATA_W'(0);
        if (r < 88)
            return CFG_DATA_W'(16'hFFFF);
        return CFG_DATA_W'($urandom());     // upper bits are don't-care
    endfunction

    task automatic load_phase_config(input int phase);
        logic [CFG_DATA_W-1:0] tgt;
        logic [CFG_DATA_W-1:0] vm;
        logic [CFG_DATA_W-1:0] kp;
        logic [CFG_DATA_W-1:0] ki;
        logic [CFG_DATA_W-1:0] kd;
        int                    r;
        if (phase == 0)
        begin
            // top of every range, limit above the rated 600 rpm
            tgt = 24'h7FFFFF;
            vm  = CFG_DATA_W'(1023);
            kp  = CFG_DATA_W'(16'hFFFF);
            ki  = CFG_DATA_W'(16'hFFFF);
            kd  = CFG_DATA_W'(16'hFFFF);
            // writes to unmapped indexes must leave the registers alone
            for (int i = int'(dpid_pkg::CFG_GAIN_D) + 1; i < (1 << CFG_IDX_W); i++)
                write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
        end
        else if (phase == 1)
        begin
            tgt = 24'h800000;
            vm  = '0;
            kp  = '0;
            ki  = '0;
            kd  = '0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                tgt = CFG_DATA_W'($urandom_range(0, 400000) - 200000);
            else if (r < 80)
                tgt = CFG_DATA_W'($urandom());
            else if (r < 85)
                tgt = '0;
            else if (r < 90)
                tgt = 24'h7FFFFF;
            else if (r < 95)
                tgt = 24'h800000;
            else
                tgt = CFG_DATA_W'($urandom_range(0, 4000) - 2000);
            r = $urandom_range(0, 99);
            if (r < 60)
                vm = CFG_DATA_W'($urandom_range(0, 600));
            else if (r < 70)
                vm = CFG_DATA_W'(600);
            else if (r < 75)
                vm = '0;
            else if (r < 85)
                vm = CFG_DATA_W'($urandom_range(601, 1023));
            else
                vm = CFG_DATA_W'($urandom());
            kp = pick_gain(20000);
            ki = pick_gain(800);
            kd = pick_gain(20000);
        end
        write_reg(dpid_pkg::CFG_TARGET, tgt);
        write_reg(dpid_pkg::CFG_MAXV, vm);
        write_reg(dpid_pkg::CFG_GAIN_P, kp);
        write_reg(dpid_pkg::CFG_GAIN_I, ki);
        write_reg(dpid_pkg::CFG_GAIN_D, kd);
        cfg_wr_en <= 1'b0;
    endtask

    // Moves toward the current target with encoder jitter and stall
    // stretches, broken up by a share of raw random ticks.
    task automatic run_moves(input int n_items);
        longint origin;
        longint cur;
        longint goal;
        longint step;
        longint offs [3];
        longint tmp;
        int     left;
        int     stall_left;
        int     sent;
        bit     rs;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                send_tick(1'($urandom_range(0, 1)), POS_W'($urandom()), POS_W'($urandom()),
                          POS_W'($urandom()), 1'b0, '0);
                sent++;
            end
            else
            begin
                origin = longint'($urandom_range(0, 8388606)) - 4194303;
                for (int i = 0; i < 3; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        offs[i] = longint'($urandom_range(0, 2097152)) - 1048576;
                    else
                        offs[i] = longint'($urandom_range(0, 6)) - 3;
                end
                cur        = origin;
                goal       = (cfg_target * 65536) / DIST_Q16
                             + longint'($urandom_range(0, 40)) - 20;
                left       = int'($urandom_range(10, 60));
                stall_left = 0;
                rs         = 1'b1;
                while (left > 0 && sent < n_items)
                begin
                    if (stall_left > 0)
                    begin
                        // hold the average; a swap changes raw counts only
                        stall_left--;
                        if ($urandom_range(0, 99) < 30)
                        begin
                            tmp     = offs[0];
                            offs[0] = offs[1];
                            offs[1] = tmp;
                        end
                    end
                    else
                    begin
                        step = (goal - (cur - origin)) / left;
                        cur  = cur + step + longint'($urandom_range(0, 8)) - 4;
                        left--;
                        if ($urandom_range(0, 99) < 6)
                            stall_left = int'($urandom_range(1, 40));
                    end
                    send_tick(rs, clamp_pos(cur + offs[0]), clamp_pos(cur + offs[1]),
                              clamp_pos(cur + offs[2]), 1'b0, '0);
                    rs = 1'b0;
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, quiet stretches, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        int len;
        int held;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                // hold off long enough for the block to back up its input
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_quiet)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 70)
            begin
                out_stall <= 1'b0;
                len = int'($urandom_range(1, 8));
                repeat (len - 1) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                len = ($urandom_range(0, 99) < 95) ? int'($urandom_range(1, 4))
                                                   : int'($urandom_range(20, 150));
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output check: every accepted command against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (drive_cmds.size() == 0)
            begin
                $error("unexpected output transaction: velocity %0d", velocity);
                fail_count++;
            end
            else
            begin
                want = drive_cmds.pop_front();
                if (velocity !== want.velocity)
                begin
                    $error("velocity mismatch: expected %0d, got %0d",
                           want.velocity, velocity);
                    fail_count++;
                end
                if (position_error !== want.position_error)
                begin
                    $error("position_error mismatch: expected %0d, got %0d",
                           want.position_error, position_error);
                    fail_count++;
                end
                if (stall_ms !== want.stall_ms)
                begin
                    $error("stall_ms mismatch: expected %0d, got %0d",
                           want.stall_ms, stall_ms);
                    fail_count++;
                end
                if (settled !== want.settled)
                begin
                    $error("settled mismatch: expected %0d, got %0d",
                           want.settled, settled);
                    fail_count++;
                end
                if (stalled !== want.stalled)
                begin
                    $error("stalled mismatch: expected %0d, got %0d",
                           want.stalled, stalled);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [POS_W-1:0] hold_pos;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        pos_a     = '0;
        pos_b     = '0;
        pos_c     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed ticks under the reset registers: target 0, P only.
        // With target 0 any move start has zero travel, so zero error.
        add_row(0, 0, 0, 0, 1, 0, 0, 0, 1, 0);          // no move yet: start one anyway
        add_row(0, 0, 0, 0, 1, 0, 0, 15, 1, 0);         // unchanged position
        add_row(0, 0, 0, 0, 1, 0, 0, 30, 1, 0);
        add_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 0);          // restart clears the timer
        add_row(1, POS_MAX, POS_MAX, POS_MAX, 1, 0, 0, 0, 1, 0);
        add_row(0, POS_MIN, POS_MIN, POS_MIN);          // full negative travel
        add_row(0, POS_MAX, POS_MAX, POS_MAX, 1, 0, 0, 0, 1, 0);
        add_row(1, POS_MIN, POS_MIN, POS_MIN, 1, 0, 0, 0, 1, 0);
        add_row(0, POS_MAX, POS_MAX, POS_MAX);          // full positive travel
        add_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_row(0, POS_MAX, POS_MIN, -1);               // sum -2 floors to -1
        add_row(0, -1, 0, 0);                           // same average
        add_row(0, 1, 1, -1);
        add_row(0, 2, 0, 0);
        add_row(0, -3, 0, 0);
        add_row(0, 0, -3, 0);                           // raw counts move, average holds
        add_row(0, 3, 0, 0);
        add_row(0, 300, 300, 300);
        add_row(0, 228, 229, 229);
        add_row(0, 24'h555555, 24'hAAAAAA, 24'h0F0F0F);
        add_row(0, 24'hF0F0F0, 24'h333333, 24'hCCCCCC);
        foreach (directed_rows[i])
            send_tick(directed_rows[i].rs, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].c, directed_rows[i].lit, directed_rows[i].res);

        // Hold one position long enough to run the stall timer past its limit.
        tx_quiet = 1'b1;
        hold_pos = POS_W'($urandom());
        send_tick(1'b1, hold_pos, hold_pos, hold_pos, 1'b0, '0);
        repeat (SAT_TICKS)
            send_tick(1'b0, hold_pos, hold_pos, hold_pos, 1'b0, '0);
        tx_quiet = 1'b0;

        // Register phases; each starts from an idle block.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            load_phase_config(ph);
            tx_quiet = (ph % 4 == 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
            rx_quiet = (ph % 4 == 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
            if (ph == 2)
            begin
                // back-to-back offers against a held-off receiver
                tx_quiet    = 1'b1;
                rx_quiet    = 1'b0;
                rx_hold_req = 1'b1;
            end
            run_moves(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && drive_cmds.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hdl/dpid_pkg.sv
hdl/dpid_div.sv
hdl/dpid_mul.sv
hdl/drive_distance_pid.sv
tb/drive_distance_pid_test.sv
